// ----- design/mbcrc_pkg.sv -----
// Shared types, status codes and the CRC-16/MODBUS byte fold for the frame checker.
// No dependencies; every other file in this folder imports it.
package mbcrc_pkg;

	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [2:0]  MIN_FRAME_BYTES = 3'd5;
	localparam logic [2:0]  FOLD_START = 3'd2;

	localparam logic [1:0] STATUS_VALID   = 2'd0;
	localparam logic [1:0] STATUS_SHORT   = 2'd1;
	localparam logic [1:0] STATUS_BAD_CRC = 2'd2;

	// One received byte word.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} rx_word_t;

	// One frame status word.
	typedef struct packed {
		logic [1:0]  frame_status;
		logic [15:0] computed_crc;
	} status_word_t;

	// Fold one byte into a reflected CRC-16, one bit per step.
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- design/mbcrc_frame.sv -----
// Per-frame state of the checker: running CRC, the two held-back bytes and the byte count.
// Depends on mbcrc_pkg for the CRC fold, status codes and word types.
module mbcrc_frame (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  mbcrc_pkg::rx_word_t     word,
	output mbcrc_pkg::status_word_t result
);
	import mbcrc_pkg::*;

	logic [15:0] crc_q;
	logic [7:0]  older_q;
	logic [7:0]  newer_q;
	logic [2:0]  count_q;

	logic [15:0] crc_next;
	logic [2:0]  count_next;
	logic [15:0] received;

	// The oldest held byte joins the CRC once two bytes are already held.
	always_comb begin
		crc_next   = (count_q >= FOLD_START) ? crc_fold(crc_q, older_q) : crc_q;
		count_next = (count_q < MIN_FRAME_BYTES) ? count_q + 3'd1 : count_q;
		received   = {word.data_byte, newer_q};
	end

	// Status for a frame that ends with this byte.
	always_comb begin
		result.computed_crc = crc_next;
		if (count_next < MIN_FRAME_BYTES) begin
			result.frame_status = STATUS_SHORT;
		end else if (received == crc_next) begin
			result.frame_status = STATUS_VALID;
		end else begin
			result.frame_status = STATUS_BAD_CRC;
		end
	end

	// Update the frame state, clearing it after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= CRC_INIT;
			older_q <= 8'h00;
			newer_q <= 8'h00;
			count_q <= 3'd0;
		end else if (step) begin
			if (word.last_byte) begin
				crc_q   <= CRC_INIT;
				older_q <= 8'h00;
				newer_q <= 8'h00;
				count_q <= 3'd0;
			end else begin
				crc_q   <= crc_next;
				older_q <= newer_q;
				newer_q <= word.data_byte;
				count_q <= count_next;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MIN_FRAME_BYTES)
		else $error("byte count passed its saturation point");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && word.last_byte |=> count_q == 3'd0 && crc_q == CRC_INIT)
		else $error("frame state not cleared after final byte");

	a_short_before_fold: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < FOLD_START |-> crc_q == CRC_INIT)
		else $error("CRC changed before two bytes were held");
`endif

endmodule

// ----- design/modbus_rtu_frame_crc_check.sv -----
// Modbus RTU received-frame CRC checker, top level.
// Depends on mbcrc_pkg and mbcrc_frame.
//
// Usage: bytes of a received frame enter one word per cycle on the rx channel
// (rx_valid/rx_ready, rx_word with data_byte and last_byte). The final byte of a
// frame carries last_byte. For each final byte the block returns one status word
// on the status channel (status_valid/status_ready, status_word): frame_status is
// valid, short (under five bytes) or CRC mismatch, and computed_crc is the
// CRC-16/MODBUS over all bytes but the last two. Other bytes give no word.
// Throughput: one byte per cycle while no final byte waits on a full result
// register, set by the input register feeding the combinational CRC fold and
// a one-entry result register.
// Reset clears the frame state (CRC 0xFFFF, no bytes held) and both valid flags.
// When the receiver stalls, the result register holds its word, a final byte
// waits in the input register, and rx_ready drops until the result is taken;
// non-final bytes keep flowing while the result register is full.
module modbus_rtu_frame_crc_check (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rx_valid,
	output logic                    rx_ready,
	input  mbcrc_pkg::rx_word_t     rx_word,
	output logic                    status_valid,
	input  logic                    status_ready,
	output mbcrc_pkg::status_word_t status_word
);
	import mbcrc_pkg::*;

	logic         valid_s1;
	rx_word_t     word_s1;
	logic         valid_s2;
	status_word_t word_s2;

	status_word_t result;
	logic         out_free;
	logic         advance;

	// The input word moves on unless it is a final byte facing a full result register.
	assign out_free = !valid_s2 || status_ready;
	assign advance  = valid_s1 && (!word_s1.last_byte || out_free);
	assign rx_ready = !valid_s1 || advance;

	mbcrc_frame u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.result (result)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			word_s1 <= rx_word;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance && word_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && word_s1.last_byte) begin
			word_s2 <= result;
		end
	end

	assign status_valid = valid_s2;
	assign status_word  = word_s2;

`ifndef NO_ASSERTIONS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> word_s2.frame_status != 2'd3)
		else $error("unused status code produced");

	a_final_waits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && word_s1.last_byte && valid_s2 && !status_ready
		|=> valid_s1 && word_s1.last_byte && $stable(word_s1))
		else $error("final byte lost while result register was full");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && word_s1.last_byte |=> valid_s2)
		else $error("final byte advanced without a status word");
`endif

endmodule
